// File: src/sse_pkg.sv
// sse_pkg: shared types and constants for the shell sort engine
// request and result structs, store geometry, store access struct
// no dependencies
package sse_pkg;

	// store geometry
	localparam int MAX_ELEMENTS = 64;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int DATA_W       = 32;

	// one input request
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} in_item_t;

	// one result
	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     final_res;
		logic                     overflow;
	} out_item_t;

	// store access from the sequencer, one write and one read port
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

// File: src/sse_store.sv
// sse_store: element store, one write port and one registered read port
// depends on sse_pkg
module sse_store (
	input  logic                        clk,
	input  sse_pkg::mem_req_t           req,
	output logic [sse_pkg::DATA_W-1:0]  rd_data
);

	logic [sse_pkg::DATA_W-1:0] mem [sse_pkg::MAX_ELEMENTS];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[req.raddr];
	end

endmodule

// File: src/sse_ctrl.sv
// sse_ctrl: load, shell sort and emit sequencer around one shared compare unit
// drives the element store through sse_pkg::mem_req_t
// depends on sse_pkg
module sse_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  sse_pkg::in_item_t           item,
	input  logic [sse_pkg::DATA_W-1:0]  rd_data,
	output sse_pkg::mem_req_t           req,
	output logic                        busy,
	output logic                        emit_s1,
	output logic                        final_s1,
	output logic                        ovf_q
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAP,
		ST_HRD,
		ST_HLD,
		ST_JRD,
		ST_CMP,
		ST_NEXT,
		ST_EMIT,
		ST_LAST
	} state_t;

	state_t                      state_q;
	logic [sse_pkg::CNT_W-1:0]   cnt_q;
	logic [sse_pkg::ADDR_W-1:0]  gap_q;
	logic [sse_pkg::ADDR_W-1:0]  i_q;
	logic [sse_pkg::ADDR_W-1:0]  j_q;
	logic [sse_pkg::ADDR_W-1:0]  k_q;
	logic [sse_pkg::DATA_W-1:0]  held_q;

	// shared compare and index units
	logic                        full;
	logic                        j_ge_gap;
	logic [sse_pkg::ADDR_W-1:0]  j_minus_gap;
	logic                        greater;
	logic [sse_pkg::CNT_W-1:0]   i_plus1;
	logic [sse_pkg::ADDR_W-1:0]  gap_half;
	logic                        k_is_last;

	assign full        = (cnt_q == sse_pkg::CNT_W'(sse_pkg::MAX_ELEMENTS));
	assign j_ge_gap    = (j_q >= gap_q);
	assign j_minus_gap = j_q - gap_q;
	assign greater     = ($signed(rd_data) > $signed(held_q));
	assign i_plus1     = {1'b0, i_q} + sse_pkg::CNT_W'(1);
	assign gap_half    = gap_q >> 1;
	assign k_is_last   = ({1'b0, k_q} == (cnt_q - sse_pkg::CNT_W'(1)));

	assign busy = (state_q != ST_IDLE);

	// store access per state
	always_comb begin
		req       = '0;
		req.raddr = i_q;
		unique case (state_q)
			ST_IDLE: begin
				req.we    = start && !full;
				req.waddr = cnt_q[sse_pkg::ADDR_W-1:0];
				req.wdata = item.value;
			end
			ST_HRD: begin
				req.raddr = i_q;
			end
			ST_JRD: begin
				if (j_ge_gap) begin
					req.raddr = j_minus_gap;
				end else begin
					req.we    = 1'b1;
					req.waddr = j_q;
					req.wdata = held_q;
				end
			end
			ST_CMP: begin
				req.we    = 1'b1;
				req.waddr = j_q;
				req.wdata = greater ? rd_data : held_q;
			end
			ST_EMIT: begin
				req.raddr = k_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			gap_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			held_q   <= '0;
			emit_s1  <= 1'b0;
			final_s1 <= 1'b0;
		end else begin
			emit_s1 <= 1'b0;
			unique case (state_q)
				// load one request per cycle
				ST_IDLE: begin
					if (start) begin
						if (!full) begin
							cnt_q <= cnt_q + sse_pkg::CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.last) begin
							state_q <= ST_GAP;
						end
					end
				end
				// first gap is half the count
				ST_GAP: begin
					gap_q <= cnt_q[sse_pkg::CNT_W-1:1];
					i_q   <= cnt_q[sse_pkg::CNT_W-1:1];
					k_q   <= '0;
					if (cnt_q[sse_pkg::CNT_W-1:1] == '0) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_HRD;
					end
				end
				// read element i
				ST_HRD: begin
					state_q <= ST_HLD;
				end
				// hold it and start the insertion walk
				ST_HLD: begin
					held_q  <= rd_data;
					j_q     <= i_q;
					state_q <= ST_JRD;
				end
				// read j-gap, or drop the held value in place
				ST_JRD: begin
					if (j_ge_gap) begin
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				// shift up or insert
				ST_CMP: begin
					if (greater) begin
						j_q     <= j_minus_gap;
						state_q <= ST_JRD;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				// next element, or next gap
				ST_NEXT: begin
					if (i_plus1 < cnt_q) begin
						i_q     <= i_plus1[sse_pkg::ADDR_W-1:0];
						state_q <= ST_HRD;
					end else begin
						gap_q <= gap_half;
						i_q   <= gap_half;
						if (gap_half == '0) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_HRD;
						end
					end
				end
				// read out in order, the result shows in the cycle after
				ST_EMIT: begin
					emit_s1  <= 1'b1;
					final_s1 <= k_is_last;
					k_q      <= k_q + sse_pkg::ADDR_W'(1);
					if (k_is_last) begin
						state_q <= ST_LAST;
					end
				end
				// final result on the ports, empty the set
				ST_LAST: begin
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/shell_sort_engine.sv
// shell_sort_engine: top level, collects a set, shell sorts it, emits it ascending
// depends on sse_pkg, sse_store, sse_ctrl
//
// usage: a request is taken at a rising edge with start high and busy low.
// each request carries one signed 32-bit value; up to 64 are stored, later
// ones are dropped and flag overflow on every result of the set. a request
// with last set ends the set: busy rises and the set is sorted by shell sort
// with gaps n/2, n/4 .. 1, all through one compare unit and one store with
// one write and one read port. load takes one request per cycle. for each gap,
// each element is read, held and walked down by insertion, shifting larger
// elements up by one gap per compare. results then follow one per cycle,
// each shown for exactly one cycle with done high, final_res on the last;
// each result is registered from the store read of its emit step, busy
// falls in the cycle after the final result, and the receiver cannot stall
// the result stream. reset clears the count, the overflow flag and the
// sequencer; the store itself is not cleared, only written entries are read.
module shell_sort_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sse_pkg::in_item_t   item,
	output logic                busy,
	output logic                done,
	output sse_pkg::out_item_t  result
);

	sse_pkg::mem_req_t           req;
	logic [sse_pkg::DATA_W-1:0]  rd_data;
	logic                        emit_s1;
	logic                        final_s1;
	logic                        ovf_q;

	sse_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	sse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.rd_data  (rd_data),
		.req      (req),
		.busy     (busy),
		.emit_s1  (emit_s1),
		.final_s1 (final_s1),
		.ovf_q    (ovf_q)
	);

	// result straight from the registered store read
	assign done                = emit_s1;
	assign result.sorted_value = $signed(rd_data);
	assign result.final_res    = final_s1;
	assign result.overflow     = ovf_q;

endmodule

// File: tb/sv/testbench.sv
// testbench: checks shell_sort_engine against a sorting tracker built into the bench
// depends on sse_pkg and shell_sort_engine
// directed sets first, then random sets of mixed size, with random idle gaps on the sender
module testbench;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_ITEMS   = 380;

	typedef enum int {
		FLAVOR_WIDE,
		FLAVOR_NARROW,
		FLAVOR_EDGE
	} value_flavor_t;

	// tracks the set being loaded and the sorted results still owed
	class sorted_output_tracker_t;
		logic signed [sse_pkg::DATA_W-1:0] held [sse_pkg::MAX_ELEMENTS];
		int                                held_count;
		bit                                overflow_seen;
		sse_pkg::out_item_t                pending_sorted [$];
		int                                mismatches;

		function new();
			held_count    = 0;
			overflow_seen = 0;
			mismatches    = 0;
		endfunction

		// halving-gap shell sort over the held entries
		function void sort_held_set();
			int                                gap;
			int                                i;
			int                                j;
			logic signed [sse_pkg::DATA_W-1:0] moving;
			for (gap = held_count / 2; gap > 0; gap = gap / 2) begin
				for (i = gap; i < held_count; i++) begin
					moving = held[i];
					j = i;
					while (j >= gap && held[j - gap] > moving) begin
						held[j] = held[j - gap];
						j = j - gap;
					end
					held[j] = moving;
				end
			end
		endfunction

		// note an accepted request, queue the sorted set when it closes
		function void take_request(sse_pkg::in_item_t req);
			sse_pkg::out_item_t expected;
			int                 k;
			if (held_count < sse_pkg::MAX_ELEMENTS) begin
				held[held_count] = req.value;
				held_count++;
			end else begin
				overflow_seen = 1;
			end
			if (req.last) begin
				sort_held_set();
				for (k = 0; k < held_count; k++) begin
					expected.sorted_value = held[k];
					expected.final_res    = (k == held_count - 1);
					expected.overflow     = overflow_seen;
					pending_sorted.push_back(expected);
				end
				held_count    = 0;
				overflow_seen = 0;
			end
		endfunction

		// compare one result against the oldest owed value
		function void check_result(sse_pkg::out_item_t got);
			sse_pkg::out_item_t expected;
			if (pending_sorted.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual value %0d final %0b overflow %0b",
					$time, got.sorted_value, got.final_res, got.overflow);
				mismatches++;
				return;
			end
			expected = pending_sorted.pop_front();
			if (got.sorted_value !== expected.sorted_value) begin
				$display("%0t: sorted_value mismatch, expected %0d actual %0d",
					$time, expected.sorted_value, got.sorted_value);
				mismatches++;
			end
			if (got.final_res !== expected.final_res) begin
				$display("%0t: final_res mismatch, expected %0b actual %0b",
					$time, expected.final_res, got.final_res);
				mismatches++;
			end
			if (got.overflow !== expected.overflow) begin
				$display("%0t: overflow mismatch, expected %0b actual %0b",
					$time, expected.overflow, got.overflow);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	sse_pkg::in_item_t  item;
	logic               busy;
	logic               done;
	sse_pkg::out_item_t result;

	sorted_output_tracker_t            board;
	logic signed [sse_pkg::DATA_W-1:0] set_values [$];
	int                                sent_items;
	bit                                idle_on;
	int                                quiet_cycles;

	shell_sort_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	// clock, period 12
	initial clk = 0;
	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// sample requests and results, watchdog on quiet cycles
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_result(result);
			if (start && !busy)
				board.take_request(item);
			if (done || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[shell_sort_engine] ERROR");
				$finish;
			end
		end
	end

	// present one request, hold it until taken
	task automatic send_item(input logic signed [sse_pkg::DATA_W-1:0] value,
		input logic last);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 37) begin
			start <= 0;
			@(negedge clk);
		end
		start      <= 1;
		item.value <= value;
		item.last  <= last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent_items++;
	endtask

	// send the queued values as one set, last on the final one
	task automatic send_set_values();
		int k;
		for (k = 0; k < set_values.size(); k++)
			send_item(set_values[k], k == set_values.size() - 1);
		set_values.delete();
	endtask

	function automatic logic signed [sse_pkg::DATA_W-1:0] pick_value(value_flavor_t flavor);
		case (flavor)
			FLAVOR_WIDE: return $urandom;
			FLAVOR_NARROW: return int'($urandom_range(16)) - 8;
			default: begin
				case ($urandom_range(4))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
		endcase
	endfunction

	// random set of the given size, overflow when above the store depth
	task automatic send_random_set(input int size);
		value_flavor_t flavor;
		int            k;
		flavor = value_flavor_t'($urandom_range(2));
		for (k = 0; k < size; k++) begin
			if ($urandom_range(3) == 0)
				set_values.push_back(pick_value(value_flavor_t'($urandom_range(2))));
			else
				set_values.push_back(pick_value(flavor));
		end
		send_set_values();
	endtask

	function automatic int pick_set_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return sse_pkg::MAX_ELEMENTS + 1 + $urandom_range(5);
		if (roll < 10)
			return sse_pkg::MAX_ELEMENTS;
		if (roll < 15)
			return $urandom_range(sse_pkg::MAX_ELEMENTS - 1, 17);
		return $urandom_range(16, 1);
	endfunction

	// stimulus and end of run
	initial begin
		board        = new();
		sent_items   = 0;
		idle_on      = 1;
		quiet_cycles = 0;
		start        = 0;
		item         = '0;
		arst_n       = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1;

		// single element sets at both extremes
		set_values = '{32'sh8000_0000};
		send_set_values();
		set_values = '{32'sh7fff_ffff};
		send_set_values();
		// pair out of order, pair of equal values
		set_values = '{32'sh7fff_ffff, 32'sh8000_0000};
		send_set_values();
		set_values = '{5, 5};
		send_set_values();
		set_values = '{0, -1, 1};
		send_set_values();
		// descending and already ascending sets
		set_values = '{32'sh7fff_ffff, 100, 3, 0, -1, -100, -5000, 32'sh8000_0000};
		send_set_values();
		set_values = '{32'sh8000_0000, -5, -1, 0, 1, 2, 1000, 32'sh7fff_ffff};
		send_set_values();

		// full store, then a set that overflows with the last request dropped
		send_random_set(sse_pkg::MAX_ELEMENTS);
		send_random_set(sse_pkg::MAX_ELEMENTS + 3);

		// random sets, with a stretch where the sender never idles
		while (sent_items < RANDOM_ITEMS) begin
			idle_on = !(sent_items > 180 && sent_items < 270);
			send_random_set(pick_set_size());
		end
		@(negedge clk);
		start <= 0;

		// drain the owed results
		while (board.pending_sorted.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("[shell_sort_engine] OK");
		else
			$display("[shell_sort_engine] ERROR");
		$finish;
	end
endmodule

// File: filelist.f
src/sse_pkg.sv
src/sse_store.sv
src/sse_ctrl.sv
src/shell_sort_engine.sv
tb/sv/testbench.sv
